/* src/fuzzy_temp_humidity_classifier_top_macros.svh */
// Assertion macros for the fuzzy temperature/humidity classifier.
`ifndef FUZZY_TEMP_HUMIDITY_CLASSIFIER_TOP_MACROS_SVH
`define FUZZY_TEMP_HUMIDITY_CLASSIFIER_TOP_MACROS_SVH

// General concurrent check, clocked on clk and disabled during rst.
`define FTHC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication: whenever ante holds, cons holds too.
`define FTHC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `FTHC_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

/* src/fthc_pkg.sv */
// Shared types, constants and grading functions for the fuzzy classifier.
package fthc_pkg;

   localparam int GRADE_W = 17;
   localparam int DIST_W  = 9;
   localparam int X_W     = 15;
   localparam int PROD_W  = 31;

   typedef logic [GRADE_W-1:0] grade_type;
   typedef logic [1:0]         class_type;

   // Triangle corners, common signed format for both axes
   localparam logic signed [X_W-1:0] T_ZERO = 15'sd0;
   localparam logic signed [X_W-1:0] T_MID  = 15'sd200;
   localparam logic signed [X_W-1:0] T_TOP  = 15'sd400;
   localparam logic signed [X_W-1:0] H_LOW  = 15'sd800;
   localparam logic signed [X_W-1:0] H_MID  = 15'sd1200;
   localparam logic signed [X_W-1:0] H_TOP  = 15'sd1600;

   localparam grade_type ONE  = 17'd65536;
   localparam grade_type NONE = 17'd0;

   // floor(n/25) = (n * RECIP) >> 26 exactly for n < 2**21.
   // n = span << 13 (half width 200) or span << 12 (half width 400).
   localparam logic [21:0] RECIP      = 22'd2684355;
   localparam int          TEMP_SHIFT = 13;
   localparam int          HUM_SHIFT  = 14;

   // Grade slots within an axis
   localparam int LO = 0;
   localparam int MD = 1;
   localparam int HI = 2;

   localparam class_type CLASS_SB = 2'd0;
   localparam class_type CLASS_B  = 2'd1;
   localparam class_type CLASS_KB = 2'd2;
   localparam class_type CLASS_BR = 2'd3;

   typedef struct packed {
      logic              apex;
      logic              outside;
      logic [DIST_W-1:0] span;
   } front_type;

   typedef struct packed {
      grade_type [2:0] t;
      grade_type [2:0] h;
   } grades_type;

   typedef grade_type [3:0] strengths_type;

   // Apex and outside tests plus distance from the nearer foot
   function automatic front_type tri_front(input logic signed [X_W-1:0] x,
                                           input logic signed [X_W-1:0] a,
                                           input logic signed [X_W-1:0] b,
                                           input logic signed [X_W-1:0] c);
      front_type             f;
      logic signed [X_W-1:0] diff;
      diff      = (x < b) ? (x - a) : (c - x);
      f.apex    = (x == b);
      f.outside = (x <= a) || (x >= c);
      f.span    = diff[DIST_W-1:0];
      return f;
   endfunction

   // Slope grade by reciprocal multiply; apex wins over outside
   function automatic grade_type tri_grade(input front_type f, input int shift);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quo;
      prod = PROD_W'(f.span) * PROD_W'(RECIP);
      quo  = prod >> shift;
      if (f.apex) begin
         return ONE;
      end else if (f.outside) begin
         return NONE;
      end else begin
         return {1'b0, quo[GRADE_W-2:0]};
      end
   endfunction

   function automatic grade_type gmin(input grade_type a, input grade_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic grade_type gmax(input grade_type a, input grade_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* src/fthc_fuzzify.sv */
// Two-stage fuzzifier: triangle tests, then slope grades by reciprocal multiply.
module fthc_fuzzify (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [13:0]         temperature,
   input  logic [10:0]                humidity,
   output logic                       out_valid,
   output fthc_pkg::grades_type       grades
);
   import fthc_pkg::*;

   logic signed [X_W-1:0] t_x;
   logic signed [X_W-1:0] h_x;

   front_type [2:0] tf_in, tf_ff;
   front_type [2:0] hf_in, hf_ff;
   logic            v1_ff;
   grades_type      grades_in, grades_ff;
   logic            v2_ff;

   assign t_x = {temperature[13], temperature};
   assign h_x = {4'b0, humidity};

   always_comb begin
      tf_in[LO] = tri_front(t_x, T_ZERO, T_ZERO, T_MID);
      tf_in[MD] = tri_front(t_x, T_ZERO, T_MID, T_TOP);
      tf_in[HI] = tri_front(t_x, T_MID, T_TOP, T_TOP);
      hf_in[LO] = tri_front(h_x, H_LOW, H_LOW, H_MID);
      hf_in[MD] = tri_front(h_x, H_LOW, H_MID, H_TOP);
      hf_in[HI] = tri_front(h_x, H_MID, H_TOP, H_TOP);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         grades_in.t[i] = tri_grade(tf_ff[i], TEMP_SHIFT);
         grades_in.h[i] = tri_grade(hf_ff[i], HUM_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      tf_ff     <= tf_in;
      hf_ff     <= hf_in;
      grades_ff <= grades_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign grades    = grades_ff;

endmodule

/* src/fthc_rules.sv */
// Rule stage: min per rule, max per class.
module fthc_rules (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  fthc_pkg::grades_type    grades,
   output logic                    out_valid,
   output fthc_pkg::strengths_type strengths
);
   import fthc_pkg::*;

   strengths_type s_in, s_ff;
   logic          v_ff;

   always_comb begin
      s_in[CLASS_SB] = gmin(grades.t[LO], grades.h[LO]);
      s_in[CLASS_B]  = gmax(gmin(grades.t[LO], grades.h[MD]),
                            gmin(grades.t[MD], grades.h[LO]));
      s_in[CLASS_KB] = gmax(gmax(gmin(grades.t[LO], grades.h[HI]),
                                 gmin(grades.t[MD], grades.h[MD])),
                            gmin(grades.t[HI], grades.h[LO]));
      s_in[CLASS_BR] = gmax(gmax(gmin(grades.t[MD], grades.h[HI]),
                                 gmin(grades.t[HI], grades.h[MD])),
                            gmin(grades.t[HI], grades.h[HI]));
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   assign out_valid = v_ff;
   assign strengths = s_ff;

endmodule

/* src/fthc_select.sv */
// Argmax stage; lower class index wins ties.
module fthc_select (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  fthc_pkg::strengths_type strengths,
   output logic                    out_valid,
   output fthc_pkg::class_type     class_code,
   output fthc_pkg::grade_type     class_strength
);
   import fthc_pkg::*;

   class_type w01, w23;
   class_type code_in, code_ff;
   grade_type str_ff;
   logic      v_ff;

   // pairwise, then final; ties keep the lower side
   always_comb begin
      w01     = (strengths[CLASS_B]  > strengths[CLASS_SB]) ? CLASS_B  : CLASS_SB;
      w23     = (strengths[CLASS_BR] > strengths[CLASS_KB]) ? CLASS_BR : CLASS_KB;
      code_in = (strengths[w23] > strengths[w01]) ? w23 : w01;
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      str_ff  <= strengths[code_in];
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   assign out_valid      = v_ff;
   assign class_code     = code_ff;
   assign class_strength = str_ff;

endmodule

/* src/fuzzy_temp_humidity_classifier_top.sv */
// Top level of the fuzzy temperature/humidity classifier.
// Usage:
//  - Command channel: a sample pair (req_temperature, 1/16 degC two's
//    complement; req_humidity, 1/16 %) transfers on a clock edge with start
//    high and busy low. busy is never raised: a new pair may be given on
//    every cycle.
//  - Result channel: rsp_valid strobes for exactly one cycle with the winning
//    class (0 SB, 1 B, 2 KB, 3 BR) and its strength (65536 = 1.0).
//  - Path: a pair taken on a clock edge passes the triangle-test, grade, rule
//    and argmax registers in order before its result shows on the result ports.
//  - Throughput: one pair per cycle, set by the four-stage pipeline
//    (triangle tests, reciprocal multiply, min/max rules, argmax), each stage
//    holding one pair.
//  - Reset (synchronous, active high) clears the stage valid bits, dropping
//    anything in flight; no result strobes until new pairs enter.
//  - The receiver cannot hold results off; each result strobes once and
//    results leave in order of entry.
module fuzzy_temp_humidity_classifier_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [13:0]  req_temperature,
   input  logic [10:0]         req_humidity,
   output logic                rsp_valid,
   output fthc_pkg::class_type rsp_class_code,
   output fthc_pkg::grade_type rsp_class_strength
);
   import fthc_pkg::*;
`include "fuzzy_temp_humidity_classifier_top_macros.svh"

   logic          accept;
   logic          fz_valid;
   grades_type    grades;
   logic          ru_valid;
   strengths_type strengths;

   // Fully pipelined: never stalls the sender
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stages 1-2: membership grades
   fthc_fuzzify u_fuzzify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .temperature (req_temperature),
      .humidity    (req_humidity),
      .out_valid   (fz_valid),
      .grades      (grades)
   );

   // Stage 3: rule base
   fthc_rules u_rules (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fz_valid),
      .grades    (grades),
      .out_valid (ru_valid),
      .strengths (strengths)
   );

   // Stage 4: strongest class, registered onto the result ports
   fthc_select u_select (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (ru_valid),
      .strengths      (strengths),
      .out_valid      (rsp_valid),
      .class_code     (rsp_class_code),
      .class_strength (rsp_class_strength)
   );

   // Checks
   `FTHC_ASSERT(a_latency, clock, reset, accept |-> ##4 rsp_valid, "result missing after transfer")
   `FTHC_ASSERT_IMP(a_zero_class, clock, reset, rsp_valid && (rsp_class_strength == NONE), rsp_class_code == CLASS_SB, "zero strength must report class SB")
   `FTHC_ASSERT_IMP(a_strength_range, clock, reset, rsp_valid, rsp_class_strength <= ONE, "strength above 1.0")

endmodule

/* tb/tb_fuzzy_temp_humidity_classifier_top.sv */
// Self-checking testbench for the fuzzy temperature/humidity classifier top level.
`timescale 1ns / 1ps

module tb_fuzzy_temp_humidity_classifier_top;
   import fthc_pkg::class_type;
   import fthc_pkg::grade_type;
   import fthc_pkg::CLASS_SB;

   // Clock period, reset length and run bounds
   localparam realtime HALF_PERIOD  = 6ns;
   localparam int      RESET_CYCLES = 9;
   localparam int      RANDOM_PAIRS = 1250;
   localparam int      DRAIN_EVERY  = 250;
   localparam int      SETTLE       = 12;      // a little beyond the four-stage pipe
   localparam int      CYCLE_LIMIT  = 400000;  // far above worst case gaps and drains
   localparam int      MAX_REPORTS  = 10;

   // Triangle corners in sensor units, and unity grade
   localparam int TEMP_ZERO = 0;
   localparam int TEMP_MID  = 200;
   localparam int TEMP_TOP  = 400;
   localparam int HUM_LOW   = 800;
   localparam int HUM_MID   = 1200;
   localparam int HUM_TOP   = 1600;
   localparam int UNITY     = 65536;

   // One queued sample pair; a drain entry holds the sender back until every
   // outstanding result has come home
   typedef struct {
      logic signed [13:0] temp;
      logic [10:0]        hum;
      int                 gap;
      bit                 drain;
   } sample_pair;

   typedef struct {
      class_type code;
      grade_type strength;
   } class_verdict;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [13:0] req_temperature;
   logic [10:0]        req_humidity;
   logic               rsp_valid;
   class_type          rsp_class_code;
   grade_type          rsp_class_strength;

   sample_pair   sample_queue[$];
   class_verdict pending_verdicts[$];
   logic         req_taken;
   int           idle_left;
   int           fault_count;

   fuzzy_temp_humidity_classifier_top uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_temperature    (req_temperature),
      .req_humidity       (req_humidity),
      .rsp_valid          (rsp_valid),
      .rsp_class_code     (rsp_class_code),
      .rsp_class_strength (rsp_class_strength)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Triangular membership: the apex is tested before the feet, so a shoulder
   // apex sitting on a foot still grades as one. Slopes truncate.
   function automatic int membership(input int x, input int a, input int b, input int c);
      if (x == b) begin
         return UNITY;
      end
      if (x <= a || x >= c) begin
         return 0;
      end
      if (x < b) begin
         return ((x - a) * UNITY) / (b - a);
      end
      return ((c - x) * UNITY) / (c - b);
   endfunction

   function automatic int lesser(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int greater(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Nine min/max rules into four class strengths, then argmax with the
   // lowest class winning a tie (strict compare keeps the earlier one)
   function automatic class_verdict classify(input logic signed [13:0] temp,
                                             input logic [10:0] hum);
      class_verdict v;
      int           t;
      int           h;
      int           cold;
      int           warm;
      int           hot;
      int           dry;
      int           mild;
      int           humid;
      int           strength[4];
      int           best;
      t     = int'(temp);
      h     = int'(hum);
      cold  = membership(t, TEMP_ZERO, TEMP_ZERO, TEMP_MID);
      warm  = membership(t, TEMP_ZERO, TEMP_MID, TEMP_TOP);
      hot   = membership(t, TEMP_MID, TEMP_TOP, TEMP_TOP);
      dry   = membership(h, HUM_LOW, HUM_LOW, HUM_MID);
      mild  = membership(h, HUM_LOW, HUM_MID, HUM_TOP);
      humid = membership(h, HUM_MID, HUM_TOP, HUM_TOP);
      strength[0] = lesser(cold, dry);
      strength[1] = greater(lesser(cold, mild), lesser(warm, dry));
      strength[2] = greater(greater(lesser(cold, humid), lesser(warm, mild)),
                            lesser(hot, dry));
      strength[3] = greater(greater(lesser(warm, humid), lesser(hot, mild)),
                            lesser(hot, humid));
      best = 0;
      for (int i = 1; i < 4; i++) begin
         if (strength[i] > strength[best]) begin
            best = i;
         end
      end
      v.code     = class_type'(best);
      v.strength = grade_type'(strength[best]);
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: inputs move on the falling edge only
   // ---------------------------------------------------------------------
   initial begin
      start           = 1'b0;
      req_temperature = '0;
      req_humidity    = '0;
      idle_left       = 0;
   end

   always @(negedge clock) begin
      sample_pair p;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // transfer not yet taken (busy high): hold the pair steady
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
         start     <= 1'b0;
      end else if (sample_queue.size() > 0 && sample_queue[0].drain) begin
         // pause the sender until the pipe has fully emptied
         start <= 1'b0;
         if (pending_verdicts.size() == 0) begin
            void'(sample_queue.pop_front());
         end
      end else if (sample_queue.size() > 0) begin
         p               = sample_queue.pop_front();
         start           <= 1'b1;
         req_temperature <= p.temp;
         req_humidity    <= p.hum;
         idle_left       <= p.gap;
      end else begin
         start <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks results and logs transfers on the rising edge
   // ---------------------------------------------------------------------
   task automatic flag_fault(input string what, input class_verdict want);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("[%0t] %s: expected class %0d strength %0d, got class %0d strength %0d",
                  $realtime, what, want.code, want.strength,
                  rsp_class_code, rsp_class_strength);
      end
   endtask

   initial begin
      fault_count = 0;
      req_taken   = 1'b0;
   end

   always @(posedge clock) begin
      class_verdict want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (pending_verdicts.size() == 0) begin
               want.code     = CLASS_SB;
               want.strength = '0;
               flag_fault("unexpected result", want);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_class_code !== want.code || rsp_class_strength !== want.strength) begin
                  flag_fault("mismatch", want);
               end
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            pending_verdicts.push_back(classify(req_temperature, req_humidity));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_pair(input int t, input int h, input int gap);
      sample_pair p;
      p.temp  = 14'(t);
      p.hum   = 11'(h);
      p.gap   = gap;
      p.drain = 1'b0;
      sample_queue.push_back(p);
   endtask

   task automatic queue_drain();
      sample_pair p;
      p.temp  = '0;
      p.hum   = '0;
      p.gap   = 0;
      p.drain = 1'b1;
      sample_queue.push_back(p);
   endtask

   // Mostly no gap, some short ones, the odd long one
   function automatic int pick_gap(input bit busy_phase);
      int r;
      if (busy_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Values on or next to an apex or foot
   function automatic int near_temp_corner();
      int corners[3];
      corners = '{TEMP_ZERO, TEMP_MID, TEMP_TOP};
      return corners[$urandom_range(0, 2)] + $urandom_range(0, 4) - 2;
   endfunction

   function automatic int near_hum_corner();
      int corners[3];
      corners = '{HUM_LOW, HUM_MID, HUM_TOP};
      return corners[$urandom_range(0, 2)] + $urandom_range(0, 4) - 2;
   endfunction

   initial begin
      int  t;
      int  h;
      int  pick;
      bit  busy_phase;

      // Directed: apexes of every triangle, each class winning outright
      queue_pair(0,     800,  0);  // cold, dry -> SB at one
      queue_pair(0,     1200, 0);  // cold, mid -> B
      queue_pair(200,   800,  0);  // warm, dry -> B
      queue_pair(200,   1200, 0);  // warm, mid -> KB
      queue_pair(0,     1600, 1);  // cold, humid -> KB
      queue_pair(400,   800,  0);  // hot, dry -> KB
      queue_pair(400,   1200, 0);  // hot, mid -> BR
      queue_pair(400,   1600, 2);  // hot, humid -> BR
      // Feet and just beyond: shoulders have no plateau
      queue_pair(-1,    800,  0);
      queue_pair(401,   1600, 0);
      queue_pair(200,   799,  0);
      queue_pair(200,   1601, 0);
      // Slopes, truncation and ties between classes
      queue_pair(100,   1000, 0);  // three-way tie (SB, B, KB), lowest class wins
      queue_pair(100,   1600, 0);  // KB and BR tie
      queue_pair(1,     801,  0);
      queue_pair(399,   1599, 0);
      queue_pair(133,   1111, 3);
      // Nothing covered, field extremes
      queue_pair(-100,  0,    0);
      queue_pair(-8192, 0,    0);
      queue_pair(8191,  2047, 0);
      queue_pair(-8192, 2047, 0);
      queue_pair(8191,  0,    0);
      queue_pair(-1,    1023, 0);
      queue_drain();

      // Random: mostly inside the covered region so the rule base is
      // exercised, plus corner hits and whole-range noise
      busy_phase = 1'b0;
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n % 100 == 0) begin
            busy_phase = ($urandom_range(0, 2) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            t = $urandom_range(0, 500) - 50;
            h = $urandom_range(750, 1650);
         end else if (pick < 80) begin
            t = near_temp_corner();
            h = near_hum_corner();
         end else begin
            t = $urandom_range(0, 16383);
            h = $urandom_range(0, 2047);
         end
         queue_pair(t, h, pick_gap(busy_phase));
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            queue_drain();
         end
      end

      // Reset once, then let the driver run the queue dry
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (sample_queue.size() > 0 || start || pending_verdicts.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
